### rtl/bpt_pkg.sv
// Shared types and codes for the bounded pair table.
package bpt_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned POS_W = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W = 5;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [FIELD_W-1:0] key_in;
		logic signed [FIELD_W-1:0] value_in;
		logic [POS_W-1:0]          position;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [FIELD_W-1:0] key_out;
		logic signed [FIELD_W-1:0] value_out;
		logic [COUNT_W-1:0]        entry_count;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_APPEND,
		S_FETCH,
		S_SHIFT,
		S_FINISH
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic                load_item;
		logic                rd_en;
		logic                res_cap;
		logic                append;
		logic                shift_wr;
		logic                cnt_dec;
		logic                out_load;
		logic                st_load;
		logic [STATUS_W-1:0] st_code;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                full;
		logic                bad_pos;
		logic                allow;
		logic                more;
		logic                match;
	} dp_stat_t;

endpackage

### rtl/bpt_datapath.sv
// Datapath of the bounded pair table: pair memory, count, pointers and result register.
module bpt_datapath import bpt_pkg::*; #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned ELEMENT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_item_t out_item
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned PW = 2 * ELEMENT_WIDTH;
	localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

	logic [PW-1:0]            mem [CAPACITY];
	logic [PW-1:0]            rd_s1;
	logic [CW-1:0]            rd_addr_s1;
	logic [CW-1:0]            shift_dst;
	logic [AW-1:0]            wr_addr;
	logic                     wr_en;
	logic [PW-1:0]            wr_data;

	logic [ACTION_W-1:0]      action_q;
	logic [ELEMENT_WIDTH-1:0] key_q;
	logic [ELEMENT_WIDTH-1:0] value_q;
	logic [POS_W-1:0]         pos_q;
	logic [CW-1:0]            ptr_q;
	logic [CW-1:0]            count_q;
	logic                     allow_q;
	logic [PW-1:0]            hold_q;
	logic [STATUS_W-1:0]      res_status_q;
	out_item_t                out_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
		end else if (cfg_wr_en) begin
			allow_q <= cfg_wr_data;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_item.action;
			key_q    <= ELEMENT_WIDTH'($unsigned(in_item.key_in));
			value_q  <= ELEMENT_WIDTH'($unsigned(in_item.value_in));
			pos_q    <= in_item.position;
		end
	end

	// Walk pointer: start at zero for add, at the position otherwise
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ptr_q <= (in_item.action == ACT_ADD) ? '0 : CW'(in_item.position);
		end else if (cmd.rd_en) begin
			ptr_q <= ptr_q + CW'(1);
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Write port: append at the end, or move an entry down one place
	assign shift_dst = rd_addr_s1 - CW'(1);
	assign wr_en     = cmd.append | cmd.shift_wr;
	assign wr_addr   = cmd.append ? count_q[AW-1:0] : shift_dst[AW-1:0];
	assign wr_data   = cmd.append ? {key_q, value_q} : rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read at the walk pointer
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1      <= mem[ptr_q[AW-1:0]];
			rd_addr_s1 <= ptr_q;
		end
	end

	// Result data and status
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			hold_q <= '0;
		end else if (cmd.res_cap) begin
			hold_q <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			res_status_q <= ST_OK;
		end else if (cmd.st_load) begin
			res_status_q <= cmd.st_code;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status      <= res_status_q;
			out_q.key_out     <= FIELD_W'(hold_q[PW-1:ELEMENT_WIDTH]);
			out_q.value_out   <= FIELD_W'(hold_q[ELEMENT_WIDTH-1:0]);
			out_q.entry_count <= COUNT_W'(count_q);
		end
	end

	assign out_item = out_q;

	// Status toward the controller
	always_comb begin
		stat.action  = action_q;
		stat.full    = (count_q >= CW'(CAPACITY));
		stat.bad_pos = (MW'(pos_q) >= MW'(count_q));
		stat.allow   = allow_q;
		stat.more    = (ptr_q < count_q);
		stat.match   = (rd_s1 == {key_q, value_q});
	end

endmodule

### rtl/bpt_ctrl.sv
// Controller state machine of the bounded pair table.
module bpt_ctrl import bpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       in_take;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				case (stat.action) inside
					ACT_ADD: begin
						if (stat.full) state_d = S_FINISH;
						else if (stat.allow || !stat.more) state_d = S_APPEND;
						else state_d = S_SCAN;
					end
					ACT_REMOVE, ACT_READ: begin
						state_d = stat.bad_pos ? S_FINISH : S_FETCH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				if (stat.match) state_d = S_FINISH;
				else if (!stat.more) state_d = S_APPEND;
			end
			S_APPEND: state_d = S_FINISH;
			S_FETCH: begin
				if (stat.action == ACT_REMOVE && stat.more) state_d = S_SHIFT;
				else state_d = S_FINISH;
			end
			S_SHIFT: begin
				if (!stat.more) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.st_code = ST_OK;
		unique case (state_q)
			S_IDLE: cmd.load_item = in_take;
			S_DECIDE: begin
				case (stat.action) inside
					ACT_ADD: begin
						if (stat.full) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_FULL;
						end else if (!stat.allow && stat.more) begin
							cmd.rd_en = 1'b1;
						end
					end
					ACT_REMOVE, ACT_READ: begin
						if (stat.bad_pos) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_BADIDX;
						end else begin
							cmd.rd_en = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_DUP;
				end else if (stat.more) begin
					cmd.rd_en = 1'b1;
				end
			end
			S_APPEND: cmd.append = 1'b1;
			S_FETCH: begin
				cmd.res_cap = 1'b1;
				if (stat.action == ACT_REMOVE) begin
					if (stat.more) cmd.rd_en = 1'b1;
					else cmd.cnt_dec = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (stat.more) cmd.rd_en = 1'b1;
				else cmd.cnt_dec = 1'b1;
			end
			S_FINISH: cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/bounded_pair_table.sv
// Top level of the bounded pair table: controller plus datapath.
//
// Ordered table of up to CAPACITY key/value pairs held in one single-port-write,
// registered-read memory. One item is worked at a time. An add appends without a
// search when duplicates are allowed or the table is empty; when duplicates are
// rejected, it first searches the stored pairs, reading one stored pair per
// cycle through the memory read port (it stops at the first match). A remove
// at position p moves each later entry down one place. A new item is taken
// while the previous result still waits in the output register; no clearing
// pass is needed after reset.
module bounded_pair_table import bpt_pkg::*; #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned ELEMENT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each item
	bpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the table and build results
	bpt_datapath #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_item    (out_item)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the bounded pair table.
`timescale 1ns / 1ps

module testbench;
	import bpt_pkg::*;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned MAX_GAP = 12;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned PRINT_LIMIT = 50;
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      cfg_wr_en;
	logic      cfg_wr_data;

	// Shadow copy of the table contents and mode
	logic [FIELD_W-1:0] tbl_key [TABLE_DEPTH];
	logic [FIELD_W-1:0] tbl_val [TABLE_DEPTH];
	int unsigned        tbl_count;
	bit                 dup_ok;

	out_item_t   pending_results [$];
	out_item_t   oldest_result;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          steady;
	bit          hold_req;

	bounded_pair_table #(
		.CAPACITY(TABLE_DEPTH),
		.ELEMENT_WIDTH(FIELD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Toggle the clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one item to the shadow table and return the result it yields
	function automatic out_item_t apply_to_table(input in_item_t it);
		out_item_t res;
		bit        found;
		res = '0;
		found = 1'b0;
		case (it.action)
			ACT_ADD: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_key[i] == it.key_in && tbl_val[i] == it.value_in)
						found = 1'b1;
				end
				if (tbl_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else if (!dup_ok && found) begin
					res.status = ST_DUP;
				end else begin
					tbl_key[tbl_count] = it.key_in;
					tbl_val[tbl_count] = it.value_in;
					tbl_count++;
				end
			end
			ACT_REMOVE, ACT_READ: begin
				if (it.position >= tbl_count) begin
					res.status = ST_BADIDX;
				end else begin
					res.key_out = tbl_key[it.position];
					res.value_out = tbl_val[it.position];
					if (it.action == ACT_REMOVE) begin
						for (int i = it.position; i + 1 < tbl_count; i++) begin
							tbl_key[i] = tbl_key[i + 1];
							tbl_val[i] = tbl_val[i + 1];
						end
						tbl_count--;
					end
				end
			end
			default: ;
		endcase
		res.entry_count = COUNT_W'(tbl_count);
		return res;
	endfunction

	function automatic in_item_t make_item(input logic [ACTION_W-1:0] act,
			input logic [FIELD_W-1:0] k, input logic [FIELD_W-1:0] v,
			input logic [POS_W-1:0] pos);
		in_item_t it;
		it.action = act;
		it.key_in = k;
		it.value_in = v;
		it.position = pos;
		return it;
	endfunction

	// Draw a field value: extremes, a few small values, or anything
	function automatic logic [FIELD_W-1:0] draw_element();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return '0;
				endcase
			end
			1, 2: return FIELD_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// Build a random item, mostly with positions that hit stored pairs
	function automatic in_item_t random_item(input int unsigned add_pct);
		in_item_t    it;
		int unsigned roll;
		int unsigned slot;
		roll = $urandom_range(0, 99);
		it = make_item(ACT_READ, draw_element(), draw_element(),
			POS_W'($urandom_range(0, TABLE_DEPTH - 1)));
		if (roll < 3) begin
			it.action = ACT_NONE;
		end else if (roll < add_pct) begin
			it.action = ACT_ADD;
			if (tbl_count > 0 && $urandom_range(0, 3) == 0) begin
				slot = $urandom_range(0, tbl_count - 1);
				it.key_in = tbl_key[slot];
				it.value_in = tbl_val[slot];
			end
		end else begin
			it.action = $urandom_range(0, 1) ? ACT_REMOVE : ACT_READ;
			if (tbl_count > 0 && $urandom_range(0, 9) < 8)
				it.position = POS_W'($urandom_range(0, tbl_count - 1));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results = {pending_results, apply_to_table(it)};
	endtask

	// Drop valid, let every result arrive, then write the mode register
	task automatic set_dup_mode(input bit allow);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= allow;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		dup_ok = allow;
	endtask

	task automatic test_empty_table();
		send_item(make_item(ACT_READ, '0, '0, 4'd0));
		send_item(make_item(ACT_REMOVE, '1, '1, 4'd15));
		send_item(make_item(ACT_NONE, 32'h8000_0000, 32'h7fff_ffff, 4'd0));
	endtask

	task automatic test_fill_to_capacity();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				0: send_item(make_item(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, 4'd0));
				1: send_item(make_item(ACT_ADD, 32'hffff_ffff, '0, 4'd15));
				default: send_item(make_item(ACT_ADD, i, ~i, POS_W'(i)));
			endcase
		end
		send_item(make_item(ACT_ADD, 32'h1234_5678, 32'h9abc_def0, 4'd0));
		send_item(make_item(ACT_NONE, '0, '0, 4'd15));
	endtask

	task automatic test_duplicate_rejection();
		set_dup_mode(1'b0);
		// Fullness wins over a duplicate pair
		send_item(make_item(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, 4'd0));
		send_item(make_item(ACT_REMOVE, '0, '0, 4'd15));
		send_item(make_item(ACT_REMOVE, '0, '0, 4'd0));
		send_item(make_item(ACT_READ, '0, '0, 4'd14));
		send_item(make_item(ACT_ADD, 32'd2, ~32'd2, 4'd0));
		send_item(make_item(ACT_ADD, 32'd2, 32'd2, 4'd0));
	endtask

	// Hold off the result side while items keep coming
	task automatic test_backpressure();
		steady = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(random_item(50));
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned add_pct [6] = '{55, 75, 30, 60, 50, 45};
		bit          mode [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		for (int p = 0; p < 6; p++) begin
			set_dup_mode(mode[p]);
			steady = (p == 2);
			for (int i = 0; i < 300; i++)
				send_item(random_item(add_pct[p]));
		end
		steady = 1'b0;
	endtask

	// Main sequence
	initial begin
		int unsigned drain_wait;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		tbl_count = 0;
		dup_ok = 1'b1;
		mismatch_count = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_fill_to_capacity();
		test_duplicate_rejection();
		test_backpressure();
		test_random_traffic();

		@(negedge clk);
		in_valid <= 1'b0;
		drain_wait = 0;
		while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				pending_results.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Stall the result side at random, or for a long hold when asked
	initial begin
		int unsigned stall_cycles;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stall_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
				if (stall_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (stall_cycles) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", out_item));
			end else begin
				oldest_result = pending_results.pop_front();
				if (out_item.status !== oldest_result.status)
					report_mismatch($sformatf("status %0d, want %0d",
						out_item.status, oldest_result.status));
				if (out_item.key_out !== oldest_result.key_out)
					report_mismatch($sformatf("key_out %h, want %h",
						out_item.key_out, oldest_result.key_out));
				if (out_item.value_out !== oldest_result.value_out)
					report_mismatch($sformatf("value_out %h, want %h",
						out_item.value_out, oldest_result.value_out));
				if (out_item.entry_count !== oldest_result.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						out_item.entry_count, oldest_result.entry_count));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
